>>> rtl/ccld_pkg.sv
// Shared types and constants of the character canvas line drawer.
`timescale 1ns / 1ps
`default_nettype none

package ccld_pkg;

  localparam int unsigned COORD_W   = 6;
  localparam int unsigned EXT_W     = COORD_W + 1;
  localparam int unsigned MARK_W    = 3;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [MARK_W-1:0] {
    MARK_BLANK     = 3'd0,
    MARK_SLASH     = 3'd1,
    MARK_BACKSLASH = 3'd2,
    MARK_DASH      = 3'd3,
    MARK_BAR       = 3'd4,
    MARK_PLUS      = 3'd5
  } mark_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    REQ_DRAW  = 1'b0,
    REQ_ERASE = 1'b1
  } req_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture and decode the input transaction
    logic rd;       // read the current cell
    logic wr;       // write the merged cell, load the result and step
    logic bad_out;  // load the rejection result
    logic clr;      // blank one cell of the clearing pass
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;
    logic last;
    logic out_free;
    logic clr_done;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/ccld_intf.sv
// Handshake channel interfaces of the character canvas line drawer.
`timescale 1ns / 1ps
`default_nettype none

interface ccld_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [ccld_pkg::COORD_W-1:0]  start_row;
  logic [ccld_pkg::COORD_W-1:0]  start_col;
  logic [ccld_pkg::COORD_W-1:0]  end_row;
  logic [ccld_pkg::COORD_W-1:0]  end_col;

  modport source (output valid, req_type, start_row, start_col, end_row, end_col,
                  input ready);
  modport sink (input valid, req_type, start_row, start_col, end_row, end_col,
                output ready);
endinterface

interface ccld_res_if;
  logic                          valid;
  logic                          ready;
  logic [ccld_pkg::COORD_W-1:0]  cell_row;
  logic [ccld_pkg::COORD_W-1:0]  cell_col;
  logic [ccld_pkg::MARK_W-1:0]   cell_mark;
  logic                          last_cell;
  logic                          bad_request;

  modport source (output valid, cell_row, cell_col, cell_mark, last_cell, bad_request,
                  input ready);
  modport sink (input valid, cell_row, cell_col, cell_mark, last_cell, bad_request,
                output ready);
endinterface

interface ccld_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ccld_pkg::CFG_IDX_W-1:0]  index;
  logic [ccld_pkg::CFG_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/ccld_ctrl.sv
// Controller state machine of the character canvas line drawer.
`timescale 1ns / 1ps
`default_nettype none

module ccld_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ccld_pkg::sts_t sts_i,
  output ccld_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_MERGE
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr     = 1'b1;
      ST_IDLE:  cmd_o.load    = in_valid_i;
      ST_CHECK: cmd_o.bad_out = sts_i.bad && sts_i.out_free;
      ST_READ:  cmd_o.rd      = 1'b1;
      ST_MERGE: cmd_o.wr      = sts_i.out_free;
      default:  cmd_o         = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_done) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!sts_i.bad) begin
            state_q <= ST_READ;
          end else if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        ST_READ: begin
          state_q <= ST_MERGE;
        end
        ST_MERGE: begin
          if (sts_i.out_free) state_q <= sts_i.last ? ST_IDLE : ST_READ;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Only one datapath command may be issued in any cycle.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

  // An accepted transaction closes the input until its results are out.
  a_load_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !in_ready_o)
    else $error("input reopened straight after a transaction");

  // The final cell of an item returns the controller to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr && sts_i.last) |=> in_ready_o)
    else $error("input not reopened after the final cell");

endmodule

`default_nettype wire

>>> rtl/ccld_dpath.sv
// Datapath of the character canvas line drawer: decode, walk, canvas memory, result register.
`timescale 1ns / 1ps
`default_nettype none

module ccld_dpath #(
  parameter int unsigned CANVAS_SIDE = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ccld_pkg::cmd_t                  cmd_i,
  output ccld_pkg::sts_t                       sts_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ccld_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ccld_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                            req_type_i,
  input  wire logic [ccld_pkg::COORD_W-1:0]    start_row_i,
  input  wire logic [ccld_pkg::COORD_W-1:0]    start_col_i,
  input  wire logic [ccld_pkg::COORD_W-1:0]    end_row_i,
  input  wire logic [ccld_pkg::COORD_W-1:0]    end_col_i,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic [ccld_pkg::COORD_W-1:0]         cell_row_o,
  output logic [ccld_pkg::COORD_W-1:0]         cell_col_o,
  output logic [ccld_pkg::MARK_W-1:0]          cell_mark_o,
  output logic                                 last_cell_o,
  output logic                                 bad_request_o
);

  localparam int unsigned COORD_W = ccld_pkg::COORD_W;
  localparam int unsigned EXT_W   = ccld_pkg::EXT_W;
  localparam int unsigned MARK_W  = ccld_pkg::MARK_W;
  localparam int unsigned SIDE_W  = $clog2(CANVAS_SIDE);
  localparam int unsigned DEPTH   = CANVAS_SIDE * CANVAS_SIDE;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam logic [EXT_W-1:0] SIDE_EXT = EXT_W'(CANVAS_SIDE);

  typedef enum logic [1:0] {
    RDIR_NONE,
    RDIR_UP,
    RDIR_DOWN
  } rdir_e;

  function automatic logic [EXT_W-1:0] sat_count(logic [ccld_pkg::CFG_W-1:0] v);
    logic [EXT_W-1:0] r;
    r = EXT_W'(v);
    if (r == '0) begin
      r = EXT_W'(1);
    end else if (r > SIDE_EXT) begin
      r = SIDE_EXT;
    end
    return r;
  endfunction

  // Effective canvas size, already saturated into 1 .. CANVAS_SIDE.
  logic [EXT_W-1:0] rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= SIDE_EXT;
      cols_q <= SIDE_EXT;
    end else if (cfg_we_i) begin
      unique case (ccld_pkg::cfg_idx_e'(cfg_idx_i))
        ccld_pkg::CFG_ROWS: rows_q <= sat_count(cfg_data_i);
        ccld_pkg::CFG_COLS: cols_q <= sat_count(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Decode of the incoming transaction.
  logic                 start_out, end_out, left_first;
  logic [COORD_W-1:0]   d_row_diff, d_col_diff;
  logic                 d_bad, d_erase, d_cstep;
  logic [COORD_W-1:0]   d_row, d_col, d_cnt, left_row, right_row;
  ccld_pkg::mark_e      d_mark;
  rdir_e                d_rdir;

  assign start_out  = ({1'b0, start_row_i} >= rows_q) || ({1'b0, start_col_i} >= cols_q);
  assign end_out    = ({1'b0, end_row_i} >= rows_q) || ({1'b0, end_col_i} >= cols_q);
  assign left_first = start_col_i < end_col_i;
  assign d_row_diff = (start_row_i > end_row_i) ? start_row_i - end_row_i
                                                : end_row_i - start_row_i;
  assign d_col_diff = (start_col_i > end_col_i) ? start_col_i - end_col_i
                                                : end_col_i - start_col_i;
  assign left_row   = left_first ? start_row_i : end_row_i;
  assign right_row  = left_first ? end_row_i : start_row_i;

  always_comb begin
    d_bad   = 1'b0;
    d_erase = 1'b0;
    d_row   = start_row_i;
    d_col   = start_col_i;
    d_cnt   = '0;
    d_mark  = ccld_pkg::MARK_DASH;
    d_rdir  = RDIR_NONE;
    d_cstep = 1'b0;
    priority if (start_out) begin
      d_bad = 1'b1;
    end else if (ccld_pkg::req_e'(req_type_i) == ccld_pkg::REQ_ERASE) begin
      d_erase = 1'b1;
      d_mark  = ccld_pkg::MARK_BLANK;
    end else if (end_out) begin
      d_bad = 1'b1;
    end else if (d_row_diff == '0) begin
      // Horizontal, including the single point.
      d_col   = left_first ? start_col_i : end_col_i;
      d_cnt   = d_col_diff;
      d_cstep = 1'b1;
    end else if (d_col_diff == '0) begin
      d_row  = (start_row_i < end_row_i) ? start_row_i : end_row_i;
      d_cnt  = d_row_diff;
      d_mark = ccld_pkg::MARK_BAR;
      d_rdir = RDIR_UP;
    end else if (d_row_diff == d_col_diff) begin
      // Diagonals are walked from the left endpoint.
      d_row   = left_row;
      d_col   = left_first ? start_col_i : end_col_i;
      d_cnt   = d_col_diff;
      d_cstep = 1'b1;
      if (right_row > left_row) begin
        d_rdir = RDIR_UP;
        d_mark = ccld_pkg::MARK_SLASH;
      end else begin
        d_rdir = RDIR_DOWN;
        d_mark = ccld_pkg::MARK_BACKSLASH;
      end
    end else begin
      d_bad = 1'b1;
    end
  end

  // Walk registers: current cell and cells still to go after it.
  logic                bad_q, erase_q, cstep_q;
  logic [COORD_W-1:0]  row_q, col_q, cnt_q;
  ccld_pkg::mark_e     mark_q;
  rdir_e               rdir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= 1'b0;
    end else if (cmd_i.load) begin
      bad_q <= d_bad;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      erase_q <= d_erase;
      cstep_q <= d_cstep;
      row_q   <= d_row;
      col_q   <= d_col;
      cnt_q   <= d_cnt;
      mark_q  <= d_mark;
      rdir_q  <= d_rdir;
    end else if (cmd_i.wr) begin
      cnt_q <= cnt_q - COORD_W'(1);
      if (cstep_q) col_q <= col_q + COORD_W'(1);
      unique case (rdir_q)
        RDIR_UP:   row_q <= row_q + COORD_W'(1);
        RDIR_DOWN: row_q <= row_q - COORD_W'(1);
        default:   row_q <= row_q;
      endcase
    end
  end

  // Rows are stored top first, so the physical row is rows - row - 1.
  logic [EXT_W-1:0]   phys_ext;
  logic [ADDR_W-1:0]  cur_addr;

  assign phys_ext = rows_q - {1'b0, row_q} - EXT_W'(1);
  assign cur_addr = ADDR_W'(phys_ext[SIDE_W-1:0]) * ADDR_W'(CANVAS_SIDE)
                  + ADDR_W'(col_q[SIDE_W-1:0]);

  // Canvas memory with its clearing pointer.
  logic [MARK_W-1:0]  canvas_q [DEPTH];
  logic [MARK_W-1:0]  rdata_q;
  logic [ADDR_W-1:0]  clr_ptr_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  waddr;
  ccld_pkg::mark_e    old_mark, new_mark, wdata;

  assign old_mark = ccld_pkg::mark_e'(rdata_q);

  always_comb begin
    if (erase_q) begin
      new_mark = ccld_pkg::MARK_BLANK;
    end else if (old_mark != ccld_pkg::MARK_BLANK && old_mark != mark_q) begin
      new_mark = ccld_pkg::MARK_PLUS;
    end else begin
      new_mark = mark_q;
    end
  end

  assign mem_we = cmd_i.wr || cmd_i.clr;
  assign waddr  = cmd_i.clr ? clr_ptr_q : cur_addr;
  assign wdata  = cmd_i.clr ? ccld_pkg::MARK_BLANK : new_mark;

  always_ff @(posedge clk_i) begin
    if (mem_we) canvas_q[waddr] <= wdata;
    if (cmd_i.rd) rdata_q <= canvas_q[cur_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_ptr_q <= clr_ptr_q + ADDR_W'(1);
    end
  end

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wr || cmd_i.bad_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      cell_row_o    <= row_q;
      cell_col_o    <= col_q;
      cell_mark_o   <= new_mark;
      last_cell_o   <= (cnt_q == '0);
      bad_request_o <= 1'b0;
    end else if (cmd_i.bad_out) begin
      cell_row_o    <= '0;
      cell_col_o    <= '0;
      cell_mark_o   <= ccld_pkg::MARK_BLANK;
      last_cell_o   <= 1'b1;
      bad_request_o <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.bad       = bad_q;
  assign sts_o.last      = (cnt_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.clr_done  = (clr_ptr_q == ADDR_W'(DEPTH - 1));

  // A result is only loaded when the result register can take it.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr || cmd_i.bad_out) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // A rejection is always the single and final result of its item.
  a_bad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.bad_out) |-> (out_valid_q && last_cell_o && bad_request_o))
    else $error("rejection result not flagged as last");

  // A waiting result keeps its fields until the transaction completes.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q &&
      $stable({cell_row_o, cell_col_o, cell_mark_o, last_cell_o, bad_request_o})))
    else $error("waiting result changed before it was taken");

endmodule

`default_nettype wire

>>> rtl/char_canvas_line_drawer.sv
// Top level of the character canvas line drawer.
//
//   Channel  Dir  Handshake       Payload
//   req_i    in   valid / ready   req_type, start_row, start_col, end_row, end_col
//   res_o    out  valid / ready   cell_row, cell_col, cell_mark, last_cell, bad_request
//   cfg_i    in   valid / ready   index (0 rows, 1 columns), data
//
// A drawn item passes one decode state after acceptance, then a read state and a
// read-modify-write state per cell on the canvas memory. A rejected item
// returns to idle from the decode state once its rejection result is loaded.
// After reset a clearing pass blanks all CANVAS_SIDE * CANVAS_SIDE cells of the
// canvas (4096 by default), with req_i.ready low; cfg_i is always ready.
// A stalled result holds the walk in its write cycle until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module char_canvas_line_drawer #(
  parameter int unsigned CANVAS_SIDE = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ccld_req_if.sink   req_i,
  ccld_res_if.source res_o,
  ccld_cfg_if.sink   cfg_i
);

  ccld_pkg::cmd_t cmd;
  ccld_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  ccld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ccld_dpath #(
    .CANVAS_SIDE (CANVAS_SIDE)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_i.valid),
    .cfg_idx_i     (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .req_type_i    (req_i.req_type),
    .start_row_i   (req_i.start_row),
    .start_col_i   (req_i.start_col),
    .end_row_i     (req_i.end_row),
    .end_col_i     (req_i.end_col),
    .out_ready_i   (res_o.ready),
    .out_valid_o   (res_o.valid),
    .cell_row_o    (res_o.cell_row),
    .cell_col_o    (res_o.cell_col),
    .cell_mark_o   (res_o.cell_mark),
    .last_cell_o   (res_o.last_cell),
    .bad_request_o (res_o.bad_request)
  );

endmodule

`default_nettype wire

>>> dv/char_canvas_line_drawer_test.sv
// Self-checking testbench for the character canvas line drawer.
`timescale 1ns / 1ps

module char_canvas_line_drawer_test;

  localparam int unsigned COORD_W     = ccld_pkg::COORD_W;
  localparam int unsigned CFG_W       = ccld_pkg::CFG_W;
  localparam int unsigned SIDE        = 64;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned TAIL_CYCLES = 2 * SIDE + 2;
  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    ccld_pkg::req_e     req_type;
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] start_col;
    logic [COORD_W-1:0] end_row;
    logic [COORD_W-1:0] end_col;
  } line_request_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    ccld_pkg::mark_e    mark;
    logic               last;
    logic               bad;
  } cell_write_t;

  class canvas_scoreboard;
    ccld_pkg::mark_e  canvas [SIDE*SIDE];
    logic [CFG_W-1:0] rows_reg;
    logic [CFG_W-1:0] cols_reg;
    cell_write_t      expected_writes [$];
    int unsigned      mismatches;

    function new();
      foreach (canvas[i]) canvas[i] = ccld_pkg::MARK_BLANK;
      rows_reg   = 7'd64;
      cols_reg   = 7'd64;
      mismatches = 0;
    endfunction

    function int unsigned in_use(logic [CFG_W-1:0] v);
      if (v < 1) return 1;
      if (v > SIDE) return SIDE;
      return v;
    endfunction

    function int unsigned rows_in_use();
      return in_use(rows_reg);
    endfunction

    function int unsigned cols_in_use();
      return in_use(cols_reg);
    endfunction

    function int unsigned pending();
      return expected_writes.size();
    endfunction

    function void set_register(ccld_pkg::cfg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        ccld_pkg::CFG_ROWS: rows_reg = v;
        ccld_pkg::CFG_COLS: cols_reg = v;
        default: ;
      endcase
    endfunction

    // Rows count from the bottom, so the stored row depends on the row count in force.
    function int unsigned slot(int unsigned rows, int unsigned r, int unsigned c);
      return ((rows - r - 1) % SIDE) * SIDE + (c % SIDE);
    endfunction

    function void push_write(int unsigned r, int unsigned c, ccld_pkg::mark_e m, bit last,
                             bit bad);
      cell_write_t w;
      w.row  = COORD_W'(r);
      w.col  = COORD_W'(c);
      w.mark = m;
      w.last = last;
      w.bad  = bad;
      expected_writes.push_back(w);
    endfunction

    function void note_request(line_request_t rq);
      int unsigned     rows, cols, sr, sc, er, ec, dr, dc, n, r0, c0, r, c, idx, k;
      int              rstep;
      ccld_pkg::mark_e stroke, merged;
      rows = rows_in_use();
      cols = cols_in_use();
      sr = rq.start_row;
      sc = rq.start_col;
      er = rq.end_row;
      ec = rq.end_col;
      if (sr >= rows || sc >= cols) begin
        push_write(0, 0, ccld_pkg::MARK_BLANK, 1'b1, 1'b1);
        return;
      end
      if (rq.req_type == ccld_pkg::REQ_ERASE) begin
        canvas[slot(rows, sr, sc)] = ccld_pkg::MARK_BLANK;
        push_write(sr, sc, ccld_pkg::MARK_BLANK, 1'b1, 1'b0);
        return;
      end
      if (er >= rows || ec >= cols) begin
        push_write(0, 0, ccld_pkg::MARK_BLANK, 1'b1, 1'b1);
        return;
      end
      dr = (sr > er) ? sr - er : er - sr;
      dc = (sc > ec) ? sc - ec : ec - sc;
      r0 = sr;
      c0 = (sc < ec) ? sc : ec;
      rstep = 0;
      if (dr == 0) begin
        n = dc + 1;
        stroke = ccld_pkg::MARK_DASH;
      end else if (dc == 0) begin
        r0 = (sr < er) ? sr : er;
        n = dr + 1;
        stroke = ccld_pkg::MARK_BAR;
      end else if (dr == dc) begin
        // The walk starts at the left-hand endpoint.
        r0 = (sc < ec) ? sr : er;
        n = dc + 1;
        if (((sc < ec) ? er : sr) > r0) begin
          rstep = 1;
          stroke = ccld_pkg::MARK_SLASH;
        end else begin
          rstep = -1;
          stroke = ccld_pkg::MARK_BACKSLASH;
        end
      end else begin
        push_write(0, 0, ccld_pkg::MARK_BLANK, 1'b1, 1'b1);
        return;
      end
      for (k = 0; k < n; k++) begin
        if (dc == 0) begin
          r = r0 + k;
          c = c0;
        end else begin
          r = (rstep > 0) ? r0 + k : (rstep < 0) ? r0 - k : r0;
          c = c0 + k;
        end
        idx = slot(rows, r, c);
        merged = (canvas[idx] != ccld_pkg::MARK_BLANK && canvas[idx] != stroke)
               ? ccld_pkg::MARK_PLUS : stroke;
        canvas[idx] = merged;
        push_write(r, c, merged, k + 1 == n, 1'b0);
      end
    endfunction

    function void flag(string what, logic [7:0] want, logic [7:0] got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_result(cell_write_t got);
      cell_write_t want;
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with nothing expected: row %0d col %0d mark %0d",
                   $time, got.row, got.col, got.mark);
        return;
      end
      want = expected_writes.pop_front();
      if (got.row !== want.row) flag("cell_row", want.row, got.row);
      if (got.col !== want.col) flag("cell_col", want.col, got.col);
      if (got.mark !== want.mark) flag("cell_mark", want.mark, got.mark);
      if (got.last !== want.last) flag("last_cell", want.last, got.last);
      if (got.bad !== want.bad) flag("bad_request", want.bad, got.bad);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ccld_req_if req_if ();
  ccld_res_if res_if ();
  ccld_cfg_if cfg_if ();

  char_canvas_line_drawer #(
    .CANVAS_SIDE(SIDE)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  canvas_scoreboard board;
  bit               steady_traffic;
  bit               hold_off_pending;
  int unsigned      cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned idle_length();
    int unsigned pick;
    if (steady_traffic) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : result_taker
    int unsigned stall;
    res_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_off_pending) begin
        stall = LONG_HOLD;
        hold_off_pending = 1'b0;
      end else begin
        stall = idle_length();
      end
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    cell_write_t got;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got.row  = res_if.cell_row;
      got.col  = res_if.cell_col;
      got.mark = ccld_pkg::mark_e'(res_if.cell_mark);
      got.last = res_if.last_cell;
      got.bad  = res_if.bad_request;
      board.check_result(got);
    end
  end

  task automatic send_request(line_request_t rq);
    int unsigned gap;
    req_if.valid     <= 1'b1;
    req_if.req_type  <= rq.req_type;
    req_if.start_row <= rq.start_row;
    req_if.start_col <= rq.start_col;
    req_if.end_row   <= rq.end_row;
    req_if.end_col   <= rq.end_col;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    board.note_request(rq);
    @(negedge clk_i);
    gap = idle_length();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_fields(ccld_pkg::req_e kind, int unsigned sr, int unsigned sc,
                             int unsigned er, int unsigned ec);
    line_request_t rq;
    rq.req_type  = kind;
    rq.start_row = COORD_W'(sr);
    rq.start_col = COORD_W'(sc);
    rq.end_row   = COORD_W'(er);
    rq.end_col   = COORD_W'(ec);
    send_request(rq);
  endtask

  function automatic line_request_t random_request(int unsigned rows, int unsigned cols);
    line_request_t rq;
    int unsigned   pick, len, span_r, span_c, r0, c0, sr, sc, er, ec, tmp;
    rq.req_type  = ccld_pkg::req_e'($urandom_range(0, 1));
    rq.start_row = COORD_W'($urandom);
    rq.start_col = COORD_W'($urandom);
    rq.end_row   = COORD_W'($urandom);
    rq.end_col   = COORD_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) return rq;
    // Each axis is narrowed to its first 8 cells half the time, so crossings and overdraws are common.
    span_r = ($urandom_range(0, 1) && rows > 8) ? 8 : rows;
    span_c = ($urandom_range(0, 1) && cols > 8) ? 8 : cols;
    if (pick < 27) begin
      rq.req_type  = ccld_pkg::REQ_ERASE;
      rq.start_row = COORD_W'($urandom_range(0, span_r - 1));
      rq.start_col = COORD_W'($urandom_range(0, span_c - 1));
      return rq;
    end
    rq.req_type = ccld_pkg::REQ_DRAW;
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 7) : $urandom_range(0, 63);
    case ($urandom_range(0, 3))
      0: begin
        sr = $urandom_range(0, span_r - 1);
        sc = $urandom_range(0, span_c - 1);
        er = sr;
        ec = sc;
      end
      1: begin
        if (len > span_c - 1) len = span_c - 1;
        sr = $urandom_range(0, span_r - 1);
        sc = $urandom_range(0, span_c - 1 - len);
        er = sr;
        ec = sc + len;
      end
      2: begin
        if (len > span_r - 1) len = span_r - 1;
        sr = $urandom_range(0, span_r - 1 - len);
        sc = $urandom_range(0, span_c - 1);
        er = sr + len;
        ec = sc;
      end
      default: begin
        tmp = (span_r < span_c) ? span_r : span_c;
        if (len > tmp - 1) len = tmp - 1;
        r0 = $urandom_range(0, span_r - 1 - len);
        c0 = $urandom_range(0, span_c - 1 - len);
        sc = c0;
        ec = c0 + len;
        if ($urandom_range(0, 1)) begin
          sr = r0;
          er = r0 + len;
        end else begin
          sr = r0 + len;
          er = r0;
        end
      end
    endcase
    if ($urandom_range(0, 1)) begin
      tmp = sr; sr = er; er = tmp;
      tmp = sc; sc = ec; ec = tmp;
    end
    rq.start_row = COORD_W'(sr);
    rq.start_col = COORD_W'(sc);
    rq.end_row   = COORD_W'(er);
    rq.end_col   = COORD_W'(ec);
    return rq;
  endfunction

  task automatic send_random(int unsigned count);
    repeat (count) send_request(random_request(board.rows_in_use(), board.cols_in_use()));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (board.pending() != 0);
  endtask

  task automatic write_register(ccld_pkg::cfg_idx_e idx, logic [CFG_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    board.set_register(idx, value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure_canvas(logic [CFG_W-1:0] rows_val, logic [CFG_W-1:0] cols_val);
    wait_drained();
    write_register(ccld_pkg::CFG_ROWS, rows_val);
    write_register(ccld_pkg::CFG_COLS, cols_val);
  endtask

  initial begin : stimulus
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = ccld_pkg::REQ_DRAW;
    req_if.start_row = '0;
    req_if.start_col = '0;
    req_if.end_row   = '0;
    req_if.end_col   = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = ccld_pkg::CFG_ROWS;
    cfg_if.data      = '0;
    steady_traffic   = 1'b0;
    hold_off_pending = 1'b0;
    board = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Full-size canvas: points, full-length lines in every direction, crossings and erases.
    send_fields(ccld_pkg::REQ_DRAW, 0, 0, 0, 0);
    send_fields(ccld_pkg::REQ_DRAW, 0, 0, 0, 0);
    send_fields(ccld_pkg::REQ_DRAW, 63, 63, 63, 0);
    send_fields(ccld_pkg::REQ_DRAW, 63, 0, 0, 0);
    send_fields(ccld_pkg::REQ_DRAW, 0, 0, 63, 63);
    send_fields(ccld_pkg::REQ_DRAW, 0, 63, 63, 0);
    send_fields(ccld_pkg::REQ_DRAW, 0, 63, 63, 63);
    send_fields(ccld_pkg::REQ_DRAW, 10, 63, 10, 63);
    send_fields(ccld_pkg::REQ_ERASE, 63, 63, 63, 63);
    send_fields(ccld_pkg::REQ_ERASE, 5, 5, 0, 0);
    send_fields(ccld_pkg::REQ_DRAW, 0, 0, 1, 2);
    send_fields(ccld_pkg::REQ_DRAW, 63, 0, 0, 62);
    send_fields(ccld_pkg::REQ_DRAW, 62, 62, 63, 63);
    send_fields(ccld_pkg::REQ_DRAW, 20, 40, 20, 40);

    // A single row: every line is horizontal, anything off row zero is refused.
    configure_canvas(7'd0, 7'd127);
    send_random(30);

    configure_canvas(7'd1, 7'd1);
    send_random(15);

    configure_canvas(7'd127, 7'd0);
    send_random(20);

    // Points beyond a reduced canvas, for both draws and erases.
    configure_canvas(7'd10, 7'd20);
    send_fields(ccld_pkg::REQ_DRAW, 10, 0, 0, 0);
    send_fields(ccld_pkg::REQ_DRAW, 0, 20, 0, 0);
    send_fields(ccld_pkg::REQ_DRAW, 0, 0, 63, 0);
    send_fields(ccld_pkg::REQ_ERASE, 9, 19, 63, 63);
    send_fields(ccld_pkg::REQ_ERASE, 10, 0, 0, 0);
    send_random(55);

    configure_canvas(7'd64, 7'd64);
    steady_traffic = 1'b1;
    send_random(75);
    wait_drained();
    steady_traffic = 1'b0;

    configure_canvas(7'd33, 7'd64);
    send_random(50);

    configure_canvas(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    send_random(40);

    // The result side stops for a long stretch while requests keep coming.
    configure_canvas(7'd2, 7'd64);
    hold_off_pending = 1'b1;
    send_random(40);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (board.pending() != 0)
      $display("%0d expected results never arrived", board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ccld_pkg.sv
rtl/ccld_intf.sv
rtl/ccld_ctrl.sv
rtl/ccld_dpath.sv
rtl/char_canvas_line_drawer.sv
dv/char_canvas_line_drawer_test.sv
